### src/ray_triangle_closest_hit_core_defines.svh
// Assertion macros for the checker file.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_CORE_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RTCH_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtch: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RTCH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtch: next-cycle check failed");

`endif

### src/rtch_pkg.sv
package rtch_pkg;

  localparam int MAX_FACES  = 64;
  localparam int FRAC_BITS  = 16;

  localparam int COORD_W    = 32;
  localparam int VERT_W     = 3 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int CROSS_W    = 2 * DIFF_W + 1;
  localparam int ACC_W      = DIFF_W + CROSS_W + 4;
  localparam int DIST_W     = 32;
  localparam int LOW_W      = DIST_W - FRAC_BITS;
  localparam int MAC_STEPS  = DIFF_W;
  localparam int CNT_W      = 6;

  localparam int SLOT_DEPTH = 3 * MAX_FACES;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int FACE_W     = $clog2(MAX_FACES);
  localparam int FCNT_W     = $clog2(MAX_FACES + 1);

  localparam int FCOUNT_W   = 7;
  localparam int TMIN_W     = 16;
  localparam int ADDR_W     = 3;

  localparam logic [FCOUNT_W-1:0] FACE_COUNT_RESET = 7'd8;
  localparam logic [TMIN_W-1:0]   T_MIN_RESET      = 16'd66;

  // Register select: byte address bit 2.
  localparam logic REG_FACE_COUNT = 1'b0;
  localparam logic REG_T_MIN      = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [1:0] CORNER_NONE = 2'd3;

  typedef struct packed {
    logic                      operation;
    logic [5:0]                face_index;
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
  } out_item_t;

  // Multiplier operand (narrow side, shifted out one bit a cycle).
  typedef enum logic [3:0] {
    XS_DX, XS_DY, XS_DZ,
    XS_E1X, XS_E1Y, XS_E1Z,
    XS_E2X, XS_E2Y, XS_E2Z,
    XS_SX, XS_SY, XS_SZ
  } xsel_t;

  // Multiplicand (wide side).
  typedef enum logic [3:0] {
    YS_E1X, YS_E1Y, YS_E1Z,
    YS_E2X, YS_E2Y, YS_E2Z,
    YS_HX, YS_HY, YS_HZ,
    YS_QX, YS_QY, YS_QZ
  } ysel_t;

  typedef enum logic [3:0] {
    D_HX, D_HY, D_HZ, D_A, D_QX, D_QY, D_QZ, D_UN, D_VN, D_TN
  } dest_t;

  typedef struct packed {
    xsel_t xs;
    ysel_t ys;
    logic  neg;
    logic  first;
    logic  last;
    dest_t dest;
  } mac_op_t;

  localparam int NUM_OPS  = 24;
  localparam int OP_IDX_W = $clog2(NUM_OPS);

  // Per-face program: h = d x e2, a = e1.h, q = s x e1, un = s.h, vn = d.q, tn = e2.q
  function automatic mac_op_t mac_program(input logic [OP_IDX_W-1:0] idx);
    mac_op_t op;
    op = '{XS_DX, YS_E1X, 1'b0, 1'b1, 1'b1, D_HX};
    unique case (idx)
      5'd0:    op = '{XS_DY,  YS_E2Z, 1'b0, 1'b1, 1'b0, D_HX};
      5'd1:    op = '{XS_DZ,  YS_E2Y, 1'b1, 1'b0, 1'b1, D_HX};
      5'd2:    op = '{XS_DZ,  YS_E2X, 1'b0, 1'b1, 1'b0, D_HY};
      5'd3:    op = '{XS_DX,  YS_E2Z, 1'b1, 1'b0, 1'b1, D_HY};
      5'd4:    op = '{XS_DX,  YS_E2Y, 1'b0, 1'b1, 1'b0, D_HZ};
      5'd5:    op = '{XS_DY,  YS_E2X, 1'b1, 1'b0, 1'b1, D_HZ};
      5'd6:    op = '{XS_E1X, YS_HX,  1'b0, 1'b1, 1'b0, D_A};
      5'd7:    op = '{XS_E1Y, YS_HY,  1'b0, 1'b0, 1'b0, D_A};
      5'd8:    op = '{XS_E1Z, YS_HZ,  1'b0, 1'b0, 1'b1, D_A};
      5'd9:    op = '{XS_SY,  YS_E1Z, 1'b0, 1'b1, 1'b0, D_QX};
      5'd10:   op = '{XS_SZ,  YS_E1Y, 1'b1, 1'b0, 1'b1, D_QX};
      5'd11:   op = '{XS_SZ,  YS_E1X, 1'b0, 1'b1, 1'b0, D_QY};
      5'd12:   op = '{XS_SX,  YS_E1Z, 1'b1, 1'b0, 1'b1, D_QY};
      5'd13:   op = '{XS_SX,  YS_E1Y, 1'b0, 1'b1, 1'b0, D_QZ};
      5'd14:   op = '{XS_SY,  YS_E1X, 1'b1, 1'b0, 1'b1, D_QZ};
      5'd15:   op = '{XS_SX,  YS_HX,  1'b0, 1'b1, 1'b0, D_UN};
      5'd16:   op = '{XS_SY,  YS_HY,  1'b0, 1'b0, 1'b0, D_UN};
      5'd17:   op = '{XS_SZ,  YS_HZ,  1'b0, 1'b0, 1'b1, D_UN};
      5'd18:   op = '{XS_DX,  YS_QX,  1'b0, 1'b1, 1'b0, D_VN};
      5'd19:   op = '{XS_DY,  YS_QY,  1'b0, 1'b0, 1'b0, D_VN};
      5'd20:   op = '{XS_DZ,  YS_QZ,  1'b0, 1'b0, 1'b1, D_VN};
      5'd21:   op = '{XS_E2X, YS_QX,  1'b0, 1'b1, 1'b0, D_TN};
      5'd22:   op = '{XS_E2Y, YS_QY,  1'b0, 1'b0, 1'b0, D_TN};
      5'd23:   op = '{XS_E2Z, YS_QZ,  1'b0, 1'b0, 1'b1, D_TN};
      default: op = '{XS_DX,  YS_E1X, 1'b0, 1'b1, 1'b1, D_HX};
    endcase
    return op;
  endfunction

endpackage

### src/ray_triangle_closest_hit_core.sv
// Closest-hit ray/triangle engine. Load triangles one corner at a time with
// operation 0 (face_index, corner 0..2 for v1..v3, vertex_x/y/z); a load
// gives no result and leaves busy low, so loads may come every cycle while
// busy is low. Cast a ray with operation 1 (origin, direction): busy rises,
// faces 0 .. min(face_count, 64)-1 are tested in order, and one result item
// (hit, hit_distance in unsigned Q16.16, zero on a miss) appears for exactly
// one cycle with done high. The receiver cannot stall that cycle, so sample
// the result when done is high. All faces share one shift-add multiplier
// (one bit of the narrow operand a cycle) and one restoring divider (one
// quotient bit a cycle). Each face is fetched, then goes through 24 products,
// the normalise and check steps, the division (skipped when the quotient
// saturates) and the compare. A face with zero determinant is dropped once
// its determinant is known; one rejected by the barycentric or sign checks
// skips the division. Only cast faces whose corners have all been loaded.
// Configuration registers over APB (write only while busy is low):
// 0x0 face_count (reset 8), 0x4 t_min (reset 66, hits need t > t_min).
module ray_triangle_closest_hit_core import rtch_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  in_item_t          request,
  output logic              done,
  output out_item_t         response
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_LOAD  = 9'b000000100,
    S_MAC   = 9'b000001000,
    S_NORM  = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_PICK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [FCOUNT_W-1:0] face_count;
  logic [TMIN_W-1:0]   t_min;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= FACE_COUNT_RESET;
      t_min      <= T_MIN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FACE_COUNT: face_count <= pwdata[FCOUNT_W-1:0];
        REG_T_MIN:      t_min      <= pwdata[TMIN_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FACE_COUNT: prdata = 32'(face_count);
      REG_T_MIN:      prdata = 32'(t_min);
      default:        prdata = '0;
    endcase
  end

  // Handshake
  logic load_accept, cast_accept, load_ok;

  assign busy        = (state != S_IDLE);
  assign load_accept = start && !busy && (request.operation == OP_LOAD);
  assign cast_accept = start && !busy && (request.operation == OP_CAST);
  assign load_ok     = load_accept && (request.corner != CORNER_NONE) &&
                       (32'(request.face_index) < MAX_FACES);

  // Corner store: one write port for loads, one registered read for fetches
  logic [VERT_W-1:0] corner_mem [0:SLOT_DEPTH-1];
  logic [VERT_W-1:0] rd_data;
  logic [SLOT_W-1:0] wr_addr, rd_addr, face_base;
  logic              rd_en;

  logic [FCNT_W-1:0] face, n_faces, n_clamped, face_inc;
  logic [1:0]        fc;
  logic              last_face;

  assign wr_addr   = SLOT_W'({request.face_index, 1'b0}) + SLOT_W'(request.face_index) +
                     SLOT_W'(request.corner);
  assign face_base = SLOT_W'({face[FACE_W-1:0], 1'b0}) + SLOT_W'(face[FACE_W-1:0]);
  assign rd_addr   = face_base + SLOT_W'(fc);
  assign rd_en     = (state == S_FETCH) && (fc != 2'd3);

  always_ff @(posedge clk) begin
    if (load_ok) begin
      corner_mem[wr_addr] <= {request.vertex_z, request.vertex_y, request.vertex_x};
    end
    if (rd_en) begin
      rd_data <= corner_mem[rd_addr];
    end
  end

  assign n_clamped = (32'(face_count) > MAX_FACES) ? FCNT_W'(MAX_FACES) : FCNT_W'(face_count);
  assign face_inc  = face + FCNT_W'(1);
  assign last_face = (face_inc == n_faces);

  // Ray and face operands
  logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz, v1x, v1y, v1z;
  logic signed [COORD_W-1:0] rx, ry, rz;
  logic signed [DIFF_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
  logic signed [CROSS_W-1:0] hx, hy, hz, qx, qy, qz;
  logic signed [ACC_W-1:0]   a_val, un, vn, tn;

  assign rx = rd_data[COORD_W-1:0];
  assign ry = rd_data[2*COORD_W-1:COORD_W];
  assign rz = rd_data[3*COORD_W-1:2*COORD_W];

  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [COORD_W-1:0] p,
    input logic signed [COORD_W-1:0] m
  );
    return $signed({p[COORD_W-1], p}) - $signed({m[COORD_W-1], m});
  endfunction

  function automatic logic signed [CROSS_W-1:0] ext_diff(input logic signed [DIFF_W-1:0] v);
    return $signed({{(CROSS_W-DIFF_W){v[DIFF_W-1]}}, v});
  endfunction

  // Shared multiply-accumulate unit
  logic [OP_IDX_W-1:0]       op_idx;
  mac_op_t                   mop;
  logic [CNT_W-1:0]          bit_cnt;
  logic [DIFF_W-1:0]         mx;
  logic signed [ACC_W-1:0]   my, acc, acc_sum, acc_next;
  logic signed [DIFF_W-1:0]  xval;
  logic signed [CROSS_W-1:0] yval;
  logic                      sub_now, mac_end, skip_zero;

  assign mop = mac_program(op_idx);

  always_comb begin
    unique case (mop.xs)
      XS_DX:   xval = $signed({dx[COORD_W-1], dx});
      XS_DY:   xval = $signed({dy[COORD_W-1], dy});
      XS_DZ:   xval = $signed({dz[COORD_W-1], dz});
      XS_E1X:  xval = e1x;
      XS_E1Y:  xval = e1y;
      XS_E1Z:  xval = e1z;
      XS_E2X:  xval = e2x;
      XS_E2Y:  xval = e2y;
      XS_E2Z:  xval = e2z;
      XS_SX:   xval = sx;
      XS_SY:   xval = sy;
      XS_SZ:   xval = sz;
      default: xval = '0;
    endcase
  end

  always_comb begin
    unique case (mop.ys)
      YS_E1X:  yval = ext_diff(e1x);
      YS_E1Y:  yval = ext_diff(e1y);
      YS_E1Z:  yval = ext_diff(e1z);
      YS_E2X:  yval = ext_diff(e2x);
      YS_E2Y:  yval = ext_diff(e2y);
      YS_E2Z:  yval = ext_diff(e2z);
      YS_HX:   yval = hx;
      YS_HY:   yval = hy;
      YS_HZ:   yval = hz;
      YS_QX:   yval = qx;
      YS_QY:   yval = qy;
      YS_QZ:   yval = qz;
      default: yval = '0;
    endcase
  end

  // The top bit of the narrow operand weighs negative; flip for a minus term.
  assign mac_end   = (bit_cnt == CNT_W'(MAC_STEPS - 1));
  assign sub_now   = mac_end ^ mop.neg;
  assign acc_sum   = sub_now ? (acc - my) : (acc + my);
  assign acc_next  = mx[0] ? acc_sum : acc;
  assign skip_zero = mop.last && (mop.dest == D_A) && (acc_next == '0);

  // Face checks and division setup
  logic signed [ACC_W:0]          uv_sum, a_ext;
  logic [ACC_W+LOW_W-1:0]         tn_wide, a_wide;
  logic                           reject, saturate;
  logic [ACC_W-1:0]               trial;
  logic                           ge;
  logic [DIST_W-1:0]              quo, div_low, best;
  logic                           found, tq_ok;
  logic [CNT_W-1:0]               div_cnt;

  assign uv_sum   = $signed({un[ACC_W-1], un}) + $signed({vn[ACC_W-1], vn});
  assign a_ext    = $signed({a_val[ACC_W-1], a_val});
  assign reject   = un[ACC_W-1] || (un > a_val) || vn[ACC_W-1] ||
                    (uv_sum > a_ext) || tn[ACC_W-1];
  assign tn_wide  = {{LOW_W{1'b0}}, tn};
  assign a_wide   = {a_val, {LOW_W{1'b0}}};
  assign saturate = (tn_wide >= a_wide);

  assign trial = {acc[ACC_W-2:0], div_low[DIST_W-1]};
  assign ge    = (trial >= $unsigned(a_val));
  assign div_cnt = bit_cnt;

  assign tq_ok = (quo > DIST_W'(t_min)) && (!found || (quo < best));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      face    <= '0;
      n_faces <= '0;
      fc      <= '0;
      op_idx  <= '0;
      bit_cnt <= '0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cast_accept) begin
            face    <= '0;
            n_faces <= n_clamped;
            fc      <= '0;
            op_idx  <= '0;
            found   <= 1'b0;
            state   <= (n_clamped == '0) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: begin
          fc <= fc + 2'd1;
          if (fc == 2'd3) begin
            op_idx <= '0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          bit_cnt <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (mac_end) begin
            if (skip_zero) begin
              // Zero determinant: drop the face
              if (last_face) begin
                state <= S_DONE;
              end else begin
                face  <= face_inc;
                fc    <= '0;
                state <= S_FETCH;
              end
            end else if (op_idx == OP_IDX_W'(NUM_OPS - 1)) begin
              state <= S_NORM;
            end else begin
              op_idx <= op_idx + OP_IDX_W'(1);
              state  <= S_LOAD;
            end
          end
        end
        S_NORM: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          bit_cnt <= '0;
          if (reject) begin
            if (last_face) begin
              state <= S_DONE;
            end else begin
              face  <= face_inc;
              fc    <= '0;
              state <= S_FETCH;
            end
          end else if (saturate) begin
            state <= S_PICK;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DIST_W - 1)) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (tq_ok) begin
            found <= 1'b1;
          end
          if (last_face) begin
            state <= S_DONE;
          end else begin
            face  <= face_inc;
            fc    <= '0;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cast_accept) begin
          ox <= request.origin_x;
          oy <= request.origin_y;
          oz <= request.origin_z;
          dx <= request.direction_x;
          dy <= request.direction_y;
          dz <= request.direction_z;
        end
      end
      S_FETCH: begin
        // rd_data holds the corner fetched in the previous cycle
        if (fc == 2'd1) begin
          v1x <= rx;
          v1y <= ry;
          v1z <= rz;
        end
        if (fc == 2'd2) begin
          e1x <= sub_ext(rx, v1x);
          e1y <= sub_ext(ry, v1y);
          e1z <= sub_ext(rz, v1z);
          sx  <= sub_ext(ox, v1x);
          sy  <= sub_ext(oy, v1y);
          sz  <= sub_ext(oz, v1z);
        end
        if (fc == 2'd3) begin
          e2x <= sub_ext(rx, v1x);
          e2y <= sub_ext(ry, v1y);
          e2z <= sub_ext(rz, v1z);
        end
      end
      S_LOAD: begin
        mx <= xval;
        my <= $signed({{(ACC_W-CROSS_W){yval[CROSS_W-1]}}, yval});
        if (mop.first) begin
          acc <= '0;
        end
      end
      S_MAC: begin
        acc <= acc_next;
        mx  <= mx >> 1;
        my  <= my <<< 1;
        if (mac_end && mop.last) begin
          unique case (mop.dest)
            D_HX:    hx    <= acc_next[CROSS_W-1:0];
            D_HY:    hy    <= acc_next[CROSS_W-1:0];
            D_HZ:    hz    <= acc_next[CROSS_W-1:0];
            D_A:     a_val <= acc_next;
            D_QX:    qx    <= acc_next[CROSS_W-1:0];
            D_QY:    qy    <= acc_next[CROSS_W-1:0];
            D_QZ:    qz    <= acc_next[CROSS_W-1:0];
            D_UN:    un    <= acc_next;
            D_VN:    vn    <= acc_next;
            D_TN:    tn    <= acc_next;
            default: ;
          endcase
        end
      end
      S_NORM: begin
        // Make the determinant positive so all checks are plain compares
        if (a_val[ACC_W-1]) begin
          a_val <= -a_val;
          un    <= -un;
          vn    <= -vn;
          tn    <= -tn;
        end
      end
      S_CHECK: begin
        // Dividend is tn << FRAC_BITS; seed the remainder with its top part
        acc     <= tn >>> LOW_W;
        div_low <= {tn[LOW_W-1:0], {FRAC_BITS{1'b0}}};
        if (saturate) begin
          quo <= '1;
        end
      end
      S_DIV: begin
        acc     <= ge ? $signed(trial - $unsigned(a_val)) : $signed(trial);
        quo     <= {quo[DIST_W-2:0], ge};
        div_low <= div_low << 1;
      end
      S_PICK: begin
        if (tq_ok) begin
          best <= quo;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign done                  = (state == S_DONE);
  assign response.hit          = found;
  assign response.hit_distance = found ? best : '0;

endmodule

### src/rtch_checker.sv
`include "ray_triangle_closest_hit_core_defines.svh"

module rtch_checker import rtch_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  request,
  input logic      done,
  input out_item_t response
);

  // A miss reports distance zero
  `RTCH_ASSERT_IMP(a_miss_zero, done && !response.hit, response.hit_distance == '0)
  // One strobe per cast
  `RTCH_ASSERT_NEXT(a_single_strobe, done, !done)
  // A cast holds the block busy; a load does not
  `RTCH_ASSERT_NEXT(a_cast_busy, start && !busy && request.operation == OP_CAST, busy)
  `RTCH_ASSERT_NEXT(a_load_free, start && !busy && request.operation == OP_LOAD, !busy)
  // The result shows while the cast is still in flight
  `RTCH_ASSERT_IMP(a_done_busy, done, busy)

endmodule

bind ray_triangle_closest_hit_core rtch_checker u_rtch_checker (.*);

### tb/tb_ray_triangle_closest_hit_core.sv
`default_nettype none

import rtch_pkg::*;

// Closest-hit predictor plus the queue of results still owed by the block.
class hit_scoreboard;
  typedef logic signed [127:0] wide_t;

  logic signed [31:0] corner_store [SLOT_DEPTH][3];
  logic [FCOUNT_W-1:0] face_count;
  logic [TMIN_W-1:0]   t_min;
  out_item_t           pending_hits[$];
  int                  errors;

  function new();
    face_count = FACE_COUNT_RESET;
    t_min      = T_MIN_RESET;
    errors     = 0;
  endfunction

  function void set_reg(logic reg_sel, logic [31:0] value);
    if (reg_sel == REG_FACE_COUNT) face_count = value[FCOUNT_W-1:0];
    else t_min = value[TMIN_W-1:0];
  endfunction

  function wide_t dot3(wide_t ax, wide_t ay, wide_t az, wide_t bx, wide_t by, wide_t bz);
    return ax * bx + ay * by + az * bz;
  endfunction

  function out_item_t closest_hit(in_item_t it);
    wide_t dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z, hx, hy, hz, a;
    wide_t sx, sy, sz, qx, qy, qz, un, vn, tn;
    logic [127:0] quot;
    logic [31:0] tq, best;
    logic found;
    int n, b;
    out_item_t r;
    found = 0;
    best = '0;
    dx = it.direction_x; dy = it.direction_y; dz = it.direction_z;
    n = (face_count > MAX_FACES) ? MAX_FACES : face_count;
    for (int f = 0; f < n; f++) begin
      b = 3 * f;
      e1x = wide_t'(corner_store[b+1][0]) - wide_t'(corner_store[b][0]);
      e1y = wide_t'(corner_store[b+1][1]) - wide_t'(corner_store[b][1]);
      e1z = wide_t'(corner_store[b+1][2]) - wide_t'(corner_store[b][2]);
      e2x = wide_t'(corner_store[b+2][0]) - wide_t'(corner_store[b][0]);
      e2y = wide_t'(corner_store[b+2][1]) - wide_t'(corner_store[b][1]);
      e2z = wide_t'(corner_store[b+2][2]) - wide_t'(corner_store[b][2]);
      hx = dy * e2z - dz * e2y;
      hy = dz * e2x - dx * e2z;
      hz = dx * e2y - dy * e2x;
      a = dot3(e1x, e1y, e1z, hx, hy, hz);
      if (a == 0) continue;
      sx = wide_t'(it.origin_x) - wide_t'(corner_store[b][0]);
      sy = wide_t'(it.origin_y) - wide_t'(corner_store[b][1]);
      sz = wide_t'(it.origin_z) - wide_t'(corner_store[b][2]);
      qx = sy * e1z - sz * e1y;
      qy = sz * e1x - sx * e1z;
      qz = sx * e1y - sy * e1x;
      un = dot3(sx, sy, sz, hx, hy, hz);
      vn = dot3(dx, dy, dz, qx, qy, qz);
      tn = dot3(e2x, e2y, e2z, qx, qy, qz);
      if (a < 0) begin
        a = -a; un = -un; vn = -vn; tn = -tn;
      end
      if (un < 0 || un > a) continue;
      if (vn < 0 || un + vn > a) continue;
      if (tn < 0) continue;
      quot = (unsigned'(tn) << FRAC_BITS) / unsigned'(a);
      tq = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      if (tq > t_min && (!found || tq < best)) begin
        best = tq;
        found = 1;
      end
    end
    r.hit = found;
    r.hit_distance = found ? best : '0;
    return r;
  endfunction

  function void note_item(in_item_t it);
    if (it.operation == OP_LOAD) begin
      if (it.corner != CORNER_NONE) begin
        corner_store[3*it.face_index + it.corner][0] = it.vertex_x;
        corner_store[3*it.face_index + it.corner][1] = it.vertex_y;
        corner_store[3*it.face_index + it.corner][2] = it.vertex_z;
      end
    end else begin
      pending_hits = {pending_hits, closest_hit(it)};
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending_hits.size() == 0) begin
      $display("%0t: unexpected result hit=%0b dist=%h", $time, got.hit, got.hit_distance);
      errors++;
      return;
    end
    want = pending_hits.pop_front();
    if (got.hit !== want.hit) begin
      $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit, got.hit);
      errors++;
    end
    if (got.hit_distance !== want.hit_distance) begin
      $display("%0t: hit_distance mismatch expected %h actual %h", $time,
               want.hit_distance, got.hit_distance);
      errors++;
    end
  endfunction
endclass

module tb_ray_triangle_closest_hit_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 0;
  logic              rst = 1;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 0;
  logic              busy;
  in_item_t          request = '0;
  logic              done;
  out_item_t         response;

  hit_scoreboard sb = new();
  int  items_sent = 0;
  // quiet turns off the random gaps for the closing stretch
  bit  quiet = 0;

  ray_triangle_closest_hit_core uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .request, .done, .response
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Every done cycle carries one result; the receiver has no say.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(response);
  end

  // Hard stop in case the block hangs.
  initial begin
    #200ms;
    $display("tb_ray_triangle_closest_hit_core: FAIL");
    $finish;
  end

  // Hold start with the item until the block takes it, then record it.
  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    start = 1;
    request = it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (!(it.operation == OP_LOAD && it.corner == CORNER_NONE)) items_sent++;
    @(negedge clk);
    start = 0;
  endtask

  // Drain outstanding casts, then write one register over APB.
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    while (sb.pending_hits.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {reg_sel, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    sb.set_reg(reg_sel, value);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic load_corner(int face, int c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_LOAD;
    it.face_index = 6'(face);
    it.corner = 2'(c);
    it.vertex_x = x; it.vertex_y = y; it.vertex_z = z;
    send(it);
  endtask

  task automatic cast_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_CAST;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
    it.direction_x = dx; it.direction_y = dy; it.direction_z = dz;
    send(it);
  endtask

  function automatic logic [31:0] rnd_span(int bits);
    return 32'(signed'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // Put a triangle whose centroid is origin + dir*k/16 into one face slot,
  // so a ray from that origin along dir crosses it at t about k/16.
  task automatic load_target_face(int face, logic signed [31:0] o[3], logic signed [31:0] d[3],
                                  int k);
    logic signed [31:0] p[3], r1[3], r2[3];
    for (int i = 0; i < 3; i++) begin
      p[i]  = o[i] + ((d[i] * k) >>> 4);
      r1[i] = rnd_span(21);
      r2[i] = rnd_span(21);
    end
    load_corner(face, 0, p[0] + r1[0], p[1] + r1[1], p[2] + r1[2]);
    load_corner(face, 1, p[0] + r2[0], p[1] + r2[1], p[2] + r2[2]);
    load_corner(face, 2, p[0] - r1[0] - r2[0], p[1] - r1[1] - r2[1], p[2] - r1[2] - r2[2]);
  endtask

  initial begin
    logic signed [31:0] o[3], d[3];
    int fc, k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Fill the whole store first so any face count reads written corners.
    for (int f = 0; f < MAX_FACES; f++)
      for (int c = 0; c < 3; c++) load_corner(f, c, $urandom, $urandom, $urandom);

    // Directed: field extremes, ignored corner, degenerate face, ties, limits.
    load_corner(5, CORNER_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    load_corner(6, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_corner(6, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    cast_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    cast_ray(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(REG_FACE_COUNT, 2);
    // zero determinant: all three corners equal
    for (int c = 0; c < 3; c++) load_corner(0, c, 32'h0001_0000, 0, 0);
    o = '{0, 0, 0};
    d = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000};
    load_target_face(1, o, d, 16);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    // tie: both faces at the same distance, the first must win
    load_target_face(0, o, d, 16);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    // tiny direction makes t huge and saturate
    cast_ray(o[0], o[1], o[2], 1, 0, 0);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    write_reg(REG_T_MIN, 16'hFFFF);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    write_reg(REG_T_MIN, 0);
    cast_ray(o[0], o[1], o[2], -d[0], -d[1], -d[2]);
    write_reg(REG_FACE_COUNT, 0);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    write_reg(REG_FACE_COUNT, 7'd127);
    cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    write_reg(REG_FACE_COUNT, 64);
    write_reg(REG_T_MIN, 66);

    // Random phases: new settings, then aimed sequences with some noise.
    while (items_sent < 500) begin
      fc = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      write_reg(REG_FACE_COUNT, fc);
      write_reg(REG_T_MIN, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                       : $urandom_range(0, 65535));
      if (items_sent > 440) quiet = 1;
      repeat (6) begin
        for (int i = 0; i < 3; i++) begin
          o[i] = rnd_span(25);
          d[i] = rnd_span(18);
        end
        for (int f = 0; f < fc; f++) begin
          k = $urandom_range(0, 5);
          if (k == 0) begin
            load_corner(f, $urandom_range(0, 3), $urandom, $urandom, $urandom);
          end else if (k == 1) begin
            load_corner(f, $urandom_range(0, 2), rnd_span(25), rnd_span(25), rnd_span(25));
          end else if (k < 5) begin
            load_target_face(f, o, d, $urandom_range(1, 64));
          end
        end
        case ($urandom_range(0, 5))
          0: cast_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          1: cast_ray(o[0], o[1], o[2], -d[0], -d[1], -d[2]);
          default: cast_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        endcase
      end
    end

    start = 0;
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("tb_ray_triangle_closest_hit_core: PASS");
    end else begin
      $display("tb_ray_triangle_closest_hit_core: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

### sim.f
+incdir+src
src/rtch_pkg.sv
src/ray_triangle_closest_hit_core.sv
src/rtch_checker.sv
tb/tb_ray_triangle_closest_hit_core.sv
